// ===== rtl/slab_object_allocator_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Slab object allocator assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ---------------------------------------------------------------------------
`ifndef SLAB_OBJECT_ALLOCATOR_UNIT_MACROS_SVH
`define SLAB_OBJECT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define SOA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slab allocator check failed");

// next-cycle implication
`define SOA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slab allocator check failed");

`endif

// ===== rtl/soa_pkg.sv =====
// ---------------------------------------------------------------------------
// Slab object allocator package
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package soa_pkg;

  localparam int MAX_SLABS_DEF   = 16;
  localparam int MAX_OBJECTS_DEF = 512;

  localparam int PAGE_SHIFT   = 12;
  localparam int HDR_BYTES    = 40;
  localparam int AVAIL_BYTES  = 4096 - HDR_BYTES;
  localparam int MIN_SIZE     = 8;
  localparam int RESET_SIZE   = 32;
  localparam int DIV_STEPS    = 12;
  localparam int USE_W        = 13;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_SHRINK  = 2'd2;
  localparam logic [1:0] CMD_DESTROY = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_CFG     = 4'd1;
  localparam logic [3:0] OP_CAP     = 4'd2;
  localparam logic [3:0] OP_LATCH   = 4'd3;
  localparam logic [3:0] OP_LOAD    = 4'd4;
  localparam logic [3:0] OP_NEXT    = 4'd5;
  localparam logic [3:0] OP_POP_RD  = 4'd6;
  localparam logic [3:0] OP_POP_WB  = 4'd7;
  localparam logic [3:0] OP_FIND    = 4'd8;
  localparam logic [3:0] OP_NEW     = 4'd9;
  localparam logic [3:0] OP_SWEEP   = 4'd10;
  localparam logic [3:0] OP_FDIV    = 4'd11;
  localparam logic [3:0] OP_FREE_WB = 4'd12;
  localparam logic [3:0] OP_REL     = 4'd13;
  localparam logic [3:0] OP_KEEP    = 4'd14;
  localparam logic [3:0] OP_SHR_END = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic       emit;
    logic [1:0] st;
    logic       taken;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       addr_zero;
    logic       div_busy;
    logic       scan_end;
    logic       cnt_nz;
    logic       page_hit;
    logic       shr_full;
    logic       can_grow;
    logic       sweep_last;
    logic       off_low;
    logic       free_bad;
    logic       in_use_nz;
    logic       pend;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/soa_datapath.sv =====
// ---------------------------------------------------------------------------
// Slab object allocator datapath
// Slab table, free-list link memory, shared divider and result register.
// ---------------------------------------------------------------------------
module soa_datapath #(
  parameter int MAX_SLABS   = soa_pkg::MAX_SLABS_DEF,
  parameter int MAX_OBJECTS = soa_pkg::MAX_OBJECTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  soa_pkg::dp_cmd_t cmd_i,
  output soa_pkg::dp_stat_t stat_o,
  input  logic [55:0]      in_tdata,
  input  logic [1:0]       in_tuser,
  input  logic [11:0]      cfg_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  localparam int SLOT_W = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int IDX_W  = $clog2(MAX_OBJECTS);
  localparam int CAP_W  = $clog2(MAX_OBJECTS + 1);
  localparam int CNT_W  = $clog2(MAX_SLABS + 1);
  localparam int AW     = SLOT_W + IDX_W;
  localparam int USE_W  = soa_pkg::USE_W;
  localparam int RCAP   = (soa_pkg::AVAIL_BYTES / soa_pkg::RESET_SIZE > MAX_OBJECTS) ?
                          MAX_OBJECTS : soa_pkg::AVAIL_BYTES / soa_pkg::RESET_SIZE;

  logic [11:0]      size_r;
  logic [CAP_W-1:0] cap_r;
  logic [MAX_SLABS-1:0] valid_r;
  logic [19:0]      page_r  [MAX_SLABS];
  logic [CAP_W-1:0] cnt_r   [MAX_SLABS];
  logic [IDX_W-1:0] head_r  [MAX_SLABS];
  logic [SLOT_W-1:0] order_r [MAX_SLABS];
  logic [CNT_W-1:0] slab_cnt_r;
  logic [USE_W-1:0] in_use_r;
  logic [USE_W-1:0] in_use_nxt;

  logic [1:0]       cmd_r;
  logic [31:0]      addr_r;
  logic [19:0]      spare_r;
  logic             spare_ok_r;
  logic [CNT_W-1:0] k_r;
  logic [CNT_W-1:0] keep_r;
  logic [SLOT_W-1:0] slot_r;
  logic [IDX_W-1:0] idx_r;
  logic             pend_r;
  logic [19:0]      pend_page_r;

  logic [11:0]      rem_r;
  logic [11:0]      quo_r;
  logic [11:0]      dsr_r;
  logic [3:0]       div_cnt_r;
  logic [12:0]      trial;

  logic [IDX_W-1:0] link_mem [2**AW];
  logic [IDX_W-1:0] mem_q_r;

  logic             out_valid_r;
  logic [71:0]      out_data_r;
  logic [1:0]       out_user_r;
  logic             out_last_r;

  logic [CAP_W-1:0] cur_cnt;
  logic [IDX_W-1:0] cur_head;
  logic [19:0]      cur_page;
  logic [11:0]      off;
  logic [SLOT_W-1:0] free_slot;
  logic [CAP_W:0]   sweep_inc;
  logic             sweep_lt;
  logic [IDX_W+11:0] prod;
  logic [31:0]      addr_calc;
  logic [11:0]      cfg_eff;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [IDX_W-1:0] mem_wd;
  logic             rel_now;

  assign cur_cnt   = cnt_r[slot_r];
  assign cur_head  = head_r[slot_r];
  assign cur_page  = page_r[slot_r];
  assign off       = addr_r[11:0];
  assign sweep_inc = (CAP_W + 1)'(idx_r) + (CAP_W + 1)'(1);
  assign sweep_lt  = sweep_inc < (CAP_W + 1)'(cap_r);
  assign prod      = (IDX_W + 12)'(idx_r) * (IDX_W + 12)'(size_r);
  assign addr_calc = {cur_page, 12'b0} + 32'(soa_pkg::HDR_BYTES) + 32'(prod);
  assign cfg_eff   = (cfg_data < 12'(soa_pkg::MIN_SIZE)) ? 12'(soa_pkg::MIN_SIZE) : cfg_data;
  assign trial     = {rem_r, quo_r[11]};
  assign rel_now   = (cmd_i.op == soa_pkg::OP_REL || cmd_i.op == soa_pkg::OP_SHR_END) && pend_r;

  always_comb begin
    free_slot = '0;
    for (int i = MAX_SLABS - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_slot = SLOT_W'(i);
    end
  end

  always_comb begin
    case (cmd_i.op)
      soa_pkg::OP_CFG:     in_use_nxt = '0;
      soa_pkg::OP_POP_WB:  in_use_nxt = in_use_r + USE_W'(1);
      soa_pkg::OP_FREE_WB: in_use_nxt = in_use_r - USE_W'(1);
      default:             in_use_nxt = in_use_r;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = {slot_r, idx_r};
    mem_wd = sweep_lt ? IDX_W'(sweep_inc) : '0;
    case (cmd_i.op)
      soa_pkg::OP_SWEEP: mem_we = 1'b1;
      soa_pkg::OP_FREE_WB: begin
        mem_we = 1'b1;
        mem_wa = {slot_r, quo_r[IDX_W-1:0]};
        mem_wd = cur_head;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_wa] <= mem_wd;
    if (cmd_i.op == soa_pkg::OP_POP_RD) mem_q_r <= link_mem[{slot_r, cur_head}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= 12'(soa_pkg::RESET_SIZE);
      cap_r      <= CAP_W'(RCAP);
      valid_r    <= '0;
      slab_cnt_r <= '0;
      in_use_r   <= '0;
      k_r        <= '0;
      keep_r     <= '0;
      pend_r     <= 1'b0;
      for (int i = 0; i < MAX_SLABS; i++) begin
        cnt_r[i]   <= '0;
        order_r[i] <= '0;
      end
    end else begin
      in_use_r <= in_use_nxt;
      case (cmd_i.op)
        soa_pkg::OP_CFG: begin
          size_r     <= cfg_eff;
          valid_r    <= '0;
          slab_cnt_r <= '0;
          for (int i = 0; i < MAX_SLABS; i++) begin
            cnt_r[i]   <= '0;
            order_r[i] <= '0;
          end
        end
        soa_pkg::OP_CAP: begin
          if (size_r >= 12'(soa_pkg::AVAIL_BYTES)) cap_r <= '0;
          else if (quo_r > 12'(MAX_OBJECTS)) cap_r <= CAP_W'(MAX_OBJECTS);
          else cap_r <= CAP_W'(quo_r);
        end
        soa_pkg::OP_LATCH: begin
          k_r    <= '0;
          keep_r <= '0;
          pend_r <= 1'b0;
        end
        soa_pkg::OP_NEXT: k_r <= k_r + CNT_W'(1);
        soa_pkg::OP_POP_WB: cnt_r[slot_r] <= cur_cnt - CAP_W'(1);
        soa_pkg::OP_NEW: begin
          valid_r[slot_r] <= 1'b1;
          cnt_r[slot_r]   <= cap_r;
          for (int i = MAX_SLABS - 1; i > 0; i--) order_r[i] <= order_r[i-1];
          order_r[0] <= slot_r;
          slab_cnt_r <= slab_cnt_r + CNT_W'(1);
        end
        soa_pkg::OP_FREE_WB: cnt_r[slot_r] <= cur_cnt + CAP_W'(1);
        soa_pkg::OP_REL: begin
          pend_r          <= 1'b1;
          valid_r[slot_r] <= 1'b0;
          cnt_r[slot_r]   <= '0;
          k_r             <= k_r + CNT_W'(1);
        end
        soa_pkg::OP_KEEP: begin
          order_r[keep_r[SLOT_W-1:0]] <= slot_r;
          keep_r <= keep_r + CNT_W'(1);
          k_r    <= k_r + CNT_W'(1);
        end
        soa_pkg::OP_SHR_END: slab_cnt_r <= keep_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd_i.op)
      soa_pkg::OP_LATCH: begin
        cmd_r      <= in_tuser;
        addr_r     <= in_tdata[31:0];
        spare_r    <= in_tdata[51:32];
        spare_ok_r <= in_tdata[52];
      end
      soa_pkg::OP_LOAD:   slot_r <= order_r[k_r[SLOT_W-1:0]];
      soa_pkg::OP_FIND:   slot_r <= free_slot;
      soa_pkg::OP_POP_RD: idx_r  <= cur_head;
      soa_pkg::OP_POP_WB: head_r[slot_r] <= mem_q_r;
      soa_pkg::OP_NEW: begin
        page_r[slot_r] <= spare_r;
        head_r[slot_r] <= '0;
        idx_r          <= '0;
      end
      soa_pkg::OP_SWEEP:   idx_r <= IDX_W'(sweep_inc);
      soa_pkg::OP_FREE_WB: head_r[slot_r] <= quo_r[IDX_W-1:0];
      soa_pkg::OP_REL:     pend_page_r <= cur_page;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd_i.op == soa_pkg::OP_CFG || cmd_i.op == soa_pkg::OP_FDIV) begin
      div_cnt_r <= 4'(soa_pkg::DIV_STEPS);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 4'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.op == soa_pkg::OP_CFG) begin
      rem_r <= '0;
      quo_r <= 12'(soa_pkg::AVAIL_BYTES);
      dsr_r <= cfg_eff;
    end else if (cmd_i.op == soa_pkg::OP_FDIV) begin
      rem_r <= '0;
      quo_r <= off - 12'(soa_pkg::HDR_BYTES);
      dsr_r <= size_r;
    end else if (div_cnt_r != '0) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_r <= 12'(trial - {1'b0, dsr_r});
        quo_r <= {quo_r[10:0], 1'b1};
      end else begin
        rem_r <= trial[11:0];
        quo_r <= {quo_r[10:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_user_r <= cmd_i.st;
      out_last_r <= cmd_i.last;
      out_data_r <= {5'b0, in_use_nxt, rel_now, rel_now ? pend_page_r : 20'b0, cmd_i.taken,
                     (cmd_i.op == soa_pkg::OP_POP_WB) ? addr_calc : 32'b0};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    stat_o.cmd        = cmd_r;
    stat_o.addr_zero  = addr_r == '0;
    stat_o.div_busy   = div_cnt_r != '0;
    stat_o.scan_end   = k_r >= slab_cnt_r;
    stat_o.cnt_nz     = cur_cnt != '0;
    stat_o.page_hit   = valid_r[slot_r] && (cur_page == addr_r[31:12]);
    stat_o.shr_full   = cur_cnt == cap_r;
    stat_o.can_grow   = spare_ok_r && (slab_cnt_r < CNT_W'(MAX_SLABS)) && (cap_r != '0);
    stat_o.sweep_last = !sweep_lt;
    stat_o.off_low    = off < 12'(soa_pkg::HDR_BYTES);
    stat_o.free_bad   = (rem_r != '0) || (quo_r >= 12'(cap_r)) || (cur_cnt >= cap_r) ||
                        (in_use_r == '0);
    stat_o.in_use_nz  = in_use_r != '0;
    stat_o.pend       = pend_r;
    stat_o.out_free   = !out_valid_r || out_tready;
  end

endmodule

// ===== rtl/soa_ctrl.sv =====
// ---------------------------------------------------------------------------
// Slab object allocator controller
// Sequences configuration, alloc, free, shrink and destroy over the datapath.
// ---------------------------------------------------------------------------
module soa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  soa_pkg::dp_stat_t stat_i,
  output soa_pkg::dp_cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CFG_DIV = 5'd1;
  localparam logic [4:0] S_DISP    = 5'd2;
  localparam logic [4:0] S_A_LOAD  = 5'd3;
  localparam logic [4:0] S_A_TEST  = 5'd4;
  localparam logic [4:0] S_A_RD    = 5'd5;
  localparam logic [4:0] S_A_WB    = 5'd6;
  localparam logic [4:0] S_A_FIND  = 5'd7;
  localparam logic [4:0] S_A_NEW   = 5'd8;
  localparam logic [4:0] S_A_SWEEP = 5'd9;
  localparam logic [4:0] S_F_LOAD  = 5'd10;
  localparam logic [4:0] S_F_TEST  = 5'd11;
  localparam logic [4:0] S_F_DIV   = 5'd12;
  localparam logic [4:0] S_F_CHK   = 5'd13;
  localparam logic [4:0] S_S_LOAD  = 5'd14;
  localparam logic [4:0] S_S_TEST  = 5'd15;
  localparam logic [4:0] S_S_END   = 5'd16;
  localparam logic [4:0] S_EMIT    = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic [1:0] st_r, st_nxt;
  logic       taken_r, taken_nxt;

  assign cfg_ready = state_r == S_IDLE;
  assign in_tready = (state_r == S_IDLE) && !cfg_valid;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    taken_nxt = taken_r;
    cmd_o     = '{op: soa_pkg::OP_NOP, emit: 1'b0, st: soa_pkg::ST_OK, taken: 1'b0, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd_o.op  = soa_pkg::OP_CFG;
          state_nxt = S_CFG_DIV;
        end else if (in_tvalid) begin
          cmd_o.op  = soa_pkg::OP_LATCH;
          taken_nxt = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_CFG_DIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.op  = soa_pkg::OP_CAP;
          state_nxt = S_IDLE;
        end
      end
      S_DISP: begin
        case (stat_i.cmd)
          soa_pkg::CMD_ALLOC: state_nxt = S_A_LOAD;
          soa_pkg::CMD_FREE: begin
            if (stat_i.addr_zero) begin
              st_nxt    = soa_pkg::ST_OK;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_F_LOAD;
            end
          end
          soa_pkg::CMD_SHRINK: state_nxt = S_S_LOAD;
          default: begin
            if (stat_i.in_use_nz) begin
              st_nxt    = soa_pkg::ST_REFUSED;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_S_LOAD;
            end
          end
        endcase
      end
      S_A_LOAD: begin
        if (stat_i.scan_end) begin
          if (stat_i.can_grow) begin
            state_nxt = S_A_FIND;
          end else begin
            st_nxt    = soa_pkg::ST_OOM;
            state_nxt = S_EMIT;
          end
        end else begin
          cmd_o.op  = soa_pkg::OP_LOAD;
          state_nxt = S_A_TEST;
        end
      end
      S_A_TEST: begin
        if (stat_i.cnt_nz) begin
          state_nxt = S_A_RD;
        end else begin
          cmd_o.op  = soa_pkg::OP_NEXT;
          state_nxt = S_A_LOAD;
        end
      end
      S_A_RD: begin
        cmd_o.op  = soa_pkg::OP_POP_RD;
        state_nxt = S_A_WB;
      end
      S_A_WB: begin
        if (stat_i.out_free) begin
          cmd_o.op    = soa_pkg::OP_POP_WB;
          cmd_o.emit  = 1'b1;
          cmd_o.taken = taken_r;
          state_nxt   = S_IDLE;
        end
      end
      S_A_FIND: begin
        cmd_o.op  = soa_pkg::OP_FIND;
        taken_nxt = 1'b1;
        state_nxt = S_A_NEW;
      end
      S_A_NEW: begin
        cmd_o.op  = soa_pkg::OP_NEW;
        state_nxt = S_A_SWEEP;
      end
      S_A_SWEEP: begin
        cmd_o.op = soa_pkg::OP_SWEEP;
        if (stat_i.sweep_last) state_nxt = S_A_RD;
      end
      S_F_LOAD: begin
        if (stat_i.scan_end) begin
          st_nxt    = soa_pkg::ST_BADFREE;
          state_nxt = S_EMIT;
        end else begin
          cmd_o.op  = soa_pkg::OP_LOAD;
          state_nxt = S_F_TEST;
        end
      end
      S_F_TEST: begin
        if (!stat_i.page_hit) begin
          cmd_o.op  = soa_pkg::OP_NEXT;
          state_nxt = S_F_LOAD;
        end else if (stat_i.off_low) begin
          st_nxt    = soa_pkg::ST_BADFREE;
          state_nxt = S_EMIT;
        end else begin
          cmd_o.op  = soa_pkg::OP_FDIV;
          state_nxt = S_F_DIV;
        end
      end
      S_F_DIV: begin
        if (!stat_i.div_busy) state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        if (stat_i.free_bad) begin
          st_nxt    = soa_pkg::ST_BADFREE;
          state_nxt = S_EMIT;
        end else if (stat_i.out_free) begin
          cmd_o.op   = soa_pkg::OP_FREE_WB;
          cmd_o.emit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_S_LOAD: begin
        if (stat_i.scan_end) begin
          state_nxt = S_S_END;
        end else begin
          cmd_o.op  = soa_pkg::OP_LOAD;
          state_nxt = S_S_TEST;
        end
      end
      S_S_TEST: begin
        if (!stat_i.shr_full) begin
          cmd_o.op  = soa_pkg::OP_KEEP;
          state_nxt = S_S_LOAD;
        end else if (!stat_i.pend || stat_i.out_free) begin
          cmd_o.op   = soa_pkg::OP_REL;
          cmd_o.emit = stat_i.pend;
          cmd_o.last = 1'b0;
          state_nxt  = S_S_LOAD;
        end
      end
      S_S_END: begin
        if (stat_i.out_free) begin
          cmd_o.op   = soa_pkg::OP_SHR_END;
          cmd_o.emit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.st   = st_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= soa_pkg::ST_OK;
      taken_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      taken_r <= taken_nxt;
    end
  end

endmodule

// ===== rtl/slab_object_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// Slab object allocator unit
// Fixed-size object allocator over one-page slabs, one command at a time.
// ---------------------------------------------------------------------------
// Channels: in_* carries commands (tuser = command, tdata = object address,
// spare page, spare valid). out_* carries results (tuser = status), tlast
// marks the final result of a command. cfg_* writes the object size.
// Sequencing: alloc scans the live slabs for one with a free object;
// building a new slab writes one free-list link per object in the slab
// (link memory write port). A free scans the live slabs for the page,
// then runs the 12-step shared divider. Shrink and destroy scan every
// live slab. A config write runs the capacity divide.
// Throughput: one command at a time; a new command is taken once the
// previous one has placed its last result in the output register.
// Reset: all slabs are forgotten, object size 32, capacity 126.
// Receiver stall: results wait in the output register; a command that needs
// to emit stalls until that register frees, and input stays blocked.
// ---------------------------------------------------------------------------
`include "slab_object_allocator_unit_macros.svh"

module slab_object_allocator_unit #(
  parameter int MAX_SLABS   = soa_pkg::MAX_SLABS_DEF,
  parameter int MAX_OBJECTS = soa_pkg::MAX_OBJECTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // object_address[31:0], spare_page[51:32],
                                  // spare_page_valid[52], zero pad
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // allocated_address[31:0], page_taken[32],
                                  // released_page[52:33], released_valid[53],
                                  // objects_in_use[66:54], zero pad
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  soa_pkg::dp_cmd_t  dp_cmd;
  soa_pkg::dp_stat_t dp_stat;

  soa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd)
  );

  soa_datapath #(
    .MAX_SLABS   (MAX_SLABS),
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `SOA_ASSERT_IMPL(a_cfg_in_excl, in_tvalid && in_tready, !(cfg_valid && cfg_ready))
  `SOA_ASSERT_NEXT(a_one_cmd, in_tvalid && in_tready, !in_tready)
  `SOA_ASSERT_IMPL(a_rel_ok, out_tvalid && out_tdata[53], out_tuser == soa_pkg::ST_OK)
  `SOA_ASSERT_IMPL(a_alloc_single, out_tvalid && (out_tdata[31:0] != 32'b0),
                   out_tlast && !out_tdata[53])

endmodule
